// ----- rtl/sha_pad_pkg.sv -----
// ----------------------------------------------------------------------------
// sha_pad_pkg
// Types and constants shared by the SHA-256 message padder and its store.
// ----------------------------------------------------------------------------
`default_nettype none

package sha_pad_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned POS_W     = 6;
  localparam int unsigned WIDX_W    = 4;
  localparam int unsigned COUNT_W   = 61;
  localparam int unsigned LEN_W     = 64;

  localparam logic [BYTE_W-1:0] PAD_MARK   = 8'h80;
  localparam logic [POS_W-1:0]  LEN_OFFSET = 6'd56;
  localparam logic [POS_W-1:0]  POS_LAST   = 6'h3F;
  localparam logic [WIDX_W-1:0] WIDX_LAST  = 4'hF;

  typedef struct packed {
    logic                  wr_en;
    logic [POS_W-1:0]      wr_addr;
    logic [BYTE_W-1:0]     wr_byte;
    logic                  rd_en;
    logic [WIDX_W-1:0]     rd_addr;
  } store_req_t;

endpackage

`default_nettype wire

// ----- rtl/sha_pad_store.sv -----
// ----------------------------------------------------------------------------
// sha_pad_store
// 64-byte block store: byte-wide writes, big-endian 32-bit word reads.
// ----------------------------------------------------------------------------
`default_nettype none

module sha_pad_store (
  input  wire                                   clk,
  input  wire sha_pad_pkg::store_req_t          req,
  output logic [sha_pad_pkg::WORD_W-1:0]        rd_word
);

  logic [sha_pad_pkg::WORD_W-1:0] mem [16];

  // byte 0 of a word sits in the top lane
  logic [1:0] lane;
  assign lane = ~req.wr_addr[1:0];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr[5:2]][{lane, 3'b000} +: 8] <= req.wr_byte;
    end
    if (req.rd_en) begin
      rd_word <= mem[req.rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/sha256_message_padder.sv -----
// Flow: a message byte is written to the store as it is taken; a byte that fills the block
// is followed by its 16 words, each read from the store (S_RD), then offered (S_OUT).
// An end item writes the 0x80 mark, then the padding and length bytes still due (a whole
// second block if the length does not fit) and emits one or two blocks; words wait on out_tready.
// Throughput: one transaction at a time; in_tready stays low until the last word is taken.
// Reset clears control state, length counter and block flags; store contents stay undefined.
// ----------------------------------------------------------------------------
// sha256_message_padder
// Collects message bytes into 64-byte blocks, appends SHA-256 padding and
// the bit length, and streams each block out as sixteen 32-bit words.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_message_padder (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,   // [7:0] data_byte
  input  wire         in_tlast,   // op: end of message
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [39:0] out_tdata,  // [31:0] block_word, [35:32] word_index, [39:36] zero
  output logic [1:0]  out_tuser,  // [0] first_block, [1] final_block
  output logic        out_tlast   // last
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_FILL,
    S_RD,
    S_OUT
  } state_t;

  state_t                            state_r;
  logic [sha_pad_pkg::POS_W-1:0]     pos_r;
  logic [sha_pad_pkg::COUNT_W-1:0]   count_r;
  logic [sha_pad_pkg::LEN_W-1:0]     len_r;
  logic [sha_pad_pkg::WIDX_W-1:0]    idx_r;
  logic                              seen_r;
  logic                              padding_r;
  logic                              extra_r;
  logic                              final_r;

  sha_pad_pkg::store_req_t           req;
  logic [sha_pad_pkg::WORD_W-1:0]    rd_word;
  logic                              in_acc;
  logic                              out_acc;
  logic                              len_zone;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_tvalid = (state_r == S_OUT);
  assign out_acc   = out_tvalid && out_tready;
  assign len_zone  = (pos_r >= sha_pad_pkg::LEN_OFFSET) && !extra_r;

  always_comb begin
    req.wr_en   = 1'b0;
    req.wr_addr = pos_r;
    req.wr_byte = '0;
    req.rd_en   = (state_r == S_RD);
    req.rd_addr = idx_r;
    unique case (state_r)
      S_IDLE: begin
        req.wr_en   = in_acc;
        req.wr_byte = in_tlast ? sha_pad_pkg::PAD_MARK : in_tdata;
      end
      S_FILL: begin
        req.wr_en   = 1'b1;
        req.wr_byte = len_zone ? len_r[63:56] : '0;
      end
      S_RD, S_OUT: begin
        req.wr_en = 1'b0;
      end
      default: begin
        req.wr_en = 1'b0;
      end
    endcase
  end

  sha_pad_store u_store (
    .clk     (clk),
    .req     (req),
    .rd_word (rd_word)
  );

  assign out_tdata = {4'b0000, idx_r, rd_word};
  assign out_tuser = {final_r, ~seen_r};
  assign out_tlast = (idx_r == sha_pad_pkg::WIDX_LAST) && (final_r || !padding_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      pos_r     <= '0;
      count_r   <= '0;
      idx_r     <= '0;
      seen_r    <= 1'b0;
      padding_r <= 1'b0;
      extra_r   <= 1'b0;
      final_r   <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            pos_r <= pos_r + 6'd1;
            idx_r <= '0;
            if (in_tlast) begin
              len_r     <= {count_r, 3'b000};
              padding_r <= 1'b1;
              final_r   <= 1'b0;
              if (pos_r == sha_pad_pkg::POS_LAST) begin
                extra_r <= 1'b0;
                state_r <= S_RD;
              end else begin
                extra_r <= (pos_r >= sha_pad_pkg::LEN_OFFSET);
                state_r <= S_FILL;
              end
            end else begin
              count_r <= count_r + 61'd1;
              if (pos_r == sha_pad_pkg::POS_LAST) begin
                final_r <= 1'b0;
                state_r <= S_RD;
              end
            end
          end
        end
        S_FILL: begin
          pos_r <= pos_r + 6'd1;
          if (len_zone) begin
            len_r <= {len_r[55:0], 8'h00};
          end
          if (pos_r == sha_pad_pkg::POS_LAST) begin
            final_r <= !extra_r;
            extra_r <= 1'b0;
            idx_r   <= '0;
            state_r <= S_RD;
          end
        end
        S_RD: begin
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_acc) begin
            idx_r <= idx_r + 4'd1;
            if (idx_r == sha_pad_pkg::WIDX_LAST) begin
              if (final_r) begin
                count_r   <= '0;
                seen_r    <= 1'b0;
                padding_r <= 1'b0;
                final_r   <= 1'b0;
                state_r   <= S_IDLE;
              end else if (padding_r) begin
                seen_r  <= 1'b1;
                state_r <= S_FILL;
              end else begin
                seen_r  <= 1'b1;
                state_r <= S_IDLE;
              end
            end else begin
              state_r <= S_RD;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input taken while a word is pending");

  a_final_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[1] && out_tdata[35:32] == 4'hF) |-> out_tlast)
    else $error("final block does not end the transaction");

  a_last_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> (out_tdata[35:32] == 4'hF))
    else $error("tlast on a word other than the last of a block");

  a_back_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> in_tready)
    else $error("not ready after the last word of a transaction");

  a_fill_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FILL && pos_r == sha_pad_pkg::POS_LAST) |=> (state_r == S_RD))
    else $error("full block not emitted");

endmodule

`default_nettype wire
